/* src/rrip_replacement_controller_unit_defines.svh */
// ----------------------------------------------------------------------------
// RRIP replacement controller assertion macros
// Shared concurrent assertion forms used by the controller's top level.
// ----------------------------------------------------------------------------
`ifndef RRIP_REPLACEMENT_CONTROLLER_UNIT_DEFINES_SVH
`define RRIP_REPLACEMENT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RRIP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rrip controller: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RRIP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rrip controller: next-cycle check failed");

`endif

/* src/rrip_pkg.sv */
// ----------------------------------------------------------------------------
// RRIP controller package
// Field widths, register indexes and re-reference constants.
// ----------------------------------------------------------------------------
package rrip_pkg;

  localparam int SET_IDX_W  = 6;
  localparam int WAY_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int THROTTLE_W = 11;
  localparam int CNT_W      = 10;
  localparam int CNT_BIT_W  = 4;

  typedef logic [1:0] rrpv_t;

  localparam rrpv_t RRPV_MAX  = 2'd3;
  localparam rrpv_t RRPV_LONG = 2'd2;
  localparam rrpv_t RRPV_NEAR = 2'd0;

  localparam logic [THROTTLE_W-1:0] THROTTLE_CAP   = 11'd1024;
  localparam logic [THROTTLE_W-1:0] THROTTLE_RESET = 11'd32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIMODAL_ENABLE = 2'd0,
    REG_THROTTLE       = 2'd1
  } reg_idx_t;

  // Status of the insertion policy unit toward the sequencer.
  typedef struct packed {
    logic  busy;
    rrpv_t ins_value;
  } ins_status_t;

endpackage

/* src/rrip_if.sv */
// ----------------------------------------------------------------------------
// RRIP controller channel interfaces
// Access request, victim response and configuration write channels.
// ----------------------------------------------------------------------------
interface rrip_req_if
  import rrip_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [SET_IDX_W-1:0] set_index;
  logic                 is_hit;
  logic [WAY_IDX_W-1:0] hit_way;

  modport source (output valid, output set_index, output is_hit, output hit_way,
                  input ready);
  modport sink (input valid, input set_index, input is_hit, input hit_way,
                output ready);
endinterface

interface rrip_rsp_if
  import rrip_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [WAY_IDX_W-1:0] victim_way;
  logic                 victim_was_valid;

  modport source (output valid, output victim_way, output victim_was_valid,
                  input ready);
  modport sink (input valid, input victim_way, input victim_was_valid,
                output ready);
endinterface

interface rrip_cfg_if
  import rrip_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [THROTTLE_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/rrip_replacement_controller_unit.sv */
// A hit writes its set in ST_LOAD, after ST_REDUCE; a miss goes on to ST_SEARCH,
// which ages the row in up to three passes until a way is found, and registers its
// result once the response slot is free. ST_REDUCE subtracts NUM_SETS while the set
// index wraps. One access at a time: the input is ready only in ST_IDLE.
// A throttle write keeps the input busy while the counter remainder is computed.
// Reset: synchronous; the set memory is then cleared, one set at a time.
// ----------------------------------------------------------------------------
// RRIP replacement controller
// Set-associative 2-bit re-reference replacement with bimodal insertion.
// ----------------------------------------------------------------------------
`include "rrip_replacement_controller_unit_defines.svh"

module rrip_replacement_controller_unit
  import rrip_pkg::*;
#(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  rrip_req_if.sink    req,
  rrip_rsp_if.source  rsp,
  rrip_cfg_if.sink    cfg
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam logic [12:0] NSETS = 13'(NUM_SETS);
  localparam logic [5:0]  NWAYS = 6'(NUM_WAYS);

  typedef struct packed {
    logic [NUM_WAYS-1:0]  vld;
    rrpv_t [NUM_WAYS-1:0] rrpv;
  } row_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_REDUCE = 5'b00100,
    ST_LOAD   = 5'b01000,
    ST_SEARCH = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [SET_W-1:0]     clr_cnt;
  logic [SET_IDX_W-1:0] set_raw;
  logic                 is_hit_q;
  logic [WAY_IDX_W-1:0] hit_way_q;
  row_t                 row;
  row_t                 rd_row;
  row_t                 hit_row;
  row_t                 fill_row;
  row_t                 mem [NUM_SETS];
  logic                 mem_we;
  logic [SET_W-1:0]     mem_waddr;
  row_t                 mem_wdata;
  logic [SET_W-1:0]     set_addr;
  logic [SET_W+SET_IDX_W-1:0] set_ext;
  logic [WAY_W+WAY_IDX_W-1:0] hway_ext;
  logic [WAY_W+WAY_IDX_W-1:0] vict_ext;
  logic [WAY_W-1:0]     hway_idx;
  logic                 hway_ok;
  logic                 set_wraps;
  logic                 found;
  logic [WAY_W-1:0]     victim;
  rrpv_t [NUM_WAYS-1:0] rrpv_aged;
  logic                 slot_free;
  logic                 commit;
  logic                 rsp_valid;
  ins_status_t          ins_status;

  // Index conversions between the fixed field widths and the array sizes.
  assign set_ext   = {{SET_W{1'b0}}, set_raw};
  assign set_addr  = set_ext[SET_W-1:0];
  assign hway_ext  = {{WAY_W{1'b0}}, hit_way_q};
  assign hway_idx  = hway_ext[WAY_W-1:0];
  assign vict_ext  = {{WAY_IDX_W{1'b0}}, victim};
  assign hway_ok   = {3'b000, hit_way_q} < NWAYS;
  assign set_wraps = {7'd0, set_raw} >= NSETS;

  assign req.ready = (state == ST_IDLE) && !ins_status.busy;
  assign rsp.valid = rsp_valid;
  assign slot_free = !rsp_valid || rsp.ready;
  assign commit    = (state == ST_SEARCH) && found && slot_free;

  rrip_search_unit #(
    .NUM_WAYS (NUM_WAYS),
    .WAY_W    (WAY_W)
  ) u_search (
    .vld       (row.vld),
    .rrpv      (row.rrpv),
    .found     (found),
    .victim    (victim),
    .rrpv_aged (rrpv_aged)
  );

  rrip_insert_ctrl u_insert (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (commit),
    .status  (ins_status)
  );

  // Row updates for a hit and for a fill.
  always_comb begin
    hit_row = rd_row;
    if (hway_ok) begin
      hit_row.rrpv[hway_idx] = RRPV_NEAR;
    end
    fill_row               = row;
    fill_row.vld[victim]   = 1'b1;
    fill_row.rrpv[victim]  = ins_status.ins_value;
  end

  // Memory write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_addr;
    mem_wdata = fill_row;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_LOAD: begin
        mem_we    = is_hit_q;
        mem_wdata = hit_row;
      end
      ST_SEARCH: begin
        mem_we = commit;
      end
      default: ;
    endcase
  end

  // Set memory: one write port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= mem[set_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!set_wraps) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = is_hit_q ? ST_IDLE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Transaction payload, working row and result registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      set_raw   <= req.set_index;
      is_hit_q  <= req.is_hit;
      hit_way_q <= req.hit_way;
    end else if ((state == ST_REDUCE) && set_wraps) begin
      set_raw <= set_raw - NSETS[SET_IDX_W-1:0];
    end
    if (state == ST_LOAD) begin
      row <= rd_row;
    end else if ((state == ST_SEARCH) && !found) begin
      row.rrpv <= rrpv_aged;
    end
    if (commit) begin
      rsp.victim_way       <= vict_ext[WAY_IDX_W-1:0];
      rsp.victim_was_valid <= row.vld[victim];
    end
  end

  `RRIP_ASSERT_IMP(a_load_after_reduce, clk, rst, state == ST_LOAD, $past(state) == ST_REDUCE)
  `RRIP_ASSERT_NXT(a_hit_no_result, clk, rst, state == ST_LOAD && is_hit_q && !rsp_valid, !rsp.valid)
  `RRIP_ASSERT_NXT(a_commit_result, clk, rst, commit, rsp.valid && state == ST_IDLE)

endmodule

/* src/rrip_search_unit.sv */
// ----------------------------------------------------------------------------
// RRIP victim search unit
// One search step over a set row: find the first invalid or distant way,
// and the aged row used when no such way exists.
// ----------------------------------------------------------------------------
module rrip_search_unit
  import rrip_pkg::*;
#(
  parameter int NUM_WAYS = 8,
  parameter int WAY_W    = 3
) (
  input  logic [NUM_WAYS-1:0]       vld,
  input  rrpv_t [NUM_WAYS-1:0]      rrpv,
  output logic                      found,
  output logic [WAY_W-1:0]          victim,
  output rrpv_t [NUM_WAYS-1:0]      rrpv_aged
);

  logic [NUM_WAYS-1:0] cand;

  // A way is a candidate when it is empty or predicted distant.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      cand[w] = !vld[w] || (rrpv[w] == RRPV_MAX);
    end
  end

  assign found = |cand;

  // Lowest-numbered candidate wins.
  always_comb begin
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        victim = WAY_W'(w);
      end
    end
  end

  // Saturating aging of every way.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv_aged[w] = (rrpv[w] == RRPV_MAX) ? RRPV_MAX : rrpv[w] + 2'd1;
    end
  end

endmodule

/* src/rrip_insert_ctrl.sv */
// ----------------------------------------------------------------------------
// RRIP insertion policy unit
// Holds the configuration registers and the bimodal miss counter, and
// renormalizes the counter against a new throttle with a bit-serial
// remainder after each throttle write.
// ----------------------------------------------------------------------------
module rrip_insert_ctrl
  import rrip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rrip_cfg_if.sink    cfg,
  input  logic        advance,
  output ins_status_t status
);

  logic                  bimodal_enable;
  logic [THROTTLE_W-1:0] throttle;
  logic [CNT_W-1:0]      miss_counter;
  logic [CNT_W-1:0]      miss_counter_next;
  logic                  norm_busy;
  logic [CNT_BIT_W-1:0]  norm_bit;
  logic [THROTTLE_W-1:0] rem;
  logic [THROTTLE_W-1:0] thr_eff;
  logic [THROTTLE_W-1:0] cnt_inc;
  logic [THROTTLE_W-1:0] rem_shift;
  logic [THROTTLE_W-1:0] rem_next;
  logic                  cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  // Throttle of zero acts as one; large values are capped.
  always_comb begin
    priority if (throttle == '0) begin
      thr_eff = THROTTLE_W'(1);
    end else if (throttle > THROTTLE_CAP) begin
      thr_eff = THROTTLE_CAP;
    end else begin
      thr_eff = throttle;
    end
  end

  // The counter stays below the throttle, so one compare wraps it.
  assign cnt_inc           = {1'b0, miss_counter} + THROTTLE_W'(1);
  assign miss_counter_next = (cnt_inc == thr_eff) ? '0 : cnt_inc[CNT_W-1:0];

  assign status.busy      = norm_busy;
  assign status.ins_value = (bimodal_enable && (miss_counter_next == '0)) ?
                            RRPV_NEAR : RRPV_LONG;

  // One restoring remainder step per cycle.
  assign rem_shift = {rem[THROTTLE_W-2:0], miss_counter[norm_bit]};
  assign rem_next  = (rem_shift >= thr_eff) ? rem_shift - thr_eff : rem_shift;

  // Configuration, counter and remainder sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      bimodal_enable <= 1'b0;
      throttle       <= THROTTLE_RESET;
      miss_counter   <= '0;
      norm_busy      <= 1'b0;
      norm_bit       <= '0;
      rem            <= '0;
    end else begin
      if (norm_busy) begin
        rem      <= rem_next;
        norm_bit <= norm_bit - CNT_BIT_W'(1);
        if (norm_bit == '0) begin
          miss_counter <= rem_next[CNT_W-1:0];
          norm_busy    <= 1'b0;
        end
      end else if (advance && bimodal_enable) begin
        miss_counter <= miss_counter_next;
      end
      if (cfg_write) begin
        unique case (cfg.index)
          REG_BIMODAL_ENABLE: bimodal_enable <= cfg.data[0];
          REG_THROTTLE: begin
            throttle  <= cfg.data;
            norm_busy <= 1'b1;
            norm_bit  <= CNT_BIT_W'(CNT_W - 1);
            rem       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/tb_rrip_replacement_controller_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RRIP replacement controller testbench
// Sends cache access transactions through directed and random phases, runs
// several insertion settings, predicts each victim and compares every result.
// ----------------------------------------------------------------------------
import rrip_pkg::*;

typedef struct packed {
  logic [WAY_IDX_W-1:0] way;
  logic                 was_valid;
} victim_t;

// Tracks the re-reference state of every set and checks the victims.
class victim_scoreboard;
  localparam int SETS = 64;
  localparam int WAYS = 8;

  rrpv_t                 rrpv [SETS][WAYS];
  bit                    line_vld [SETS][WAYS];
  logic [CNT_W-1:0]      miss_cnt;
  bit                    bimodal;
  logic [THROTTLE_W-1:0] throttle;
  victim_t               pending_victims [$];
  int errors;
  int hits;
  int misses;
  int agings;
  int near_inserts;
  int reg_writes;

  function new();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        rrpv[s][w]     = RRPV_NEAR;
        line_vld[s][w] = 1'b0;
      end
    end
    miss_cnt     = '0;
    bimodal      = 1'b0;
    throttle     = THROTTLE_RESET;
    errors       = 0;
    hits         = 0;
    misses       = 0;
    agings       = 0;
    near_inserts = 0;
    reg_writes   = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [THROTTLE_W-1:0] val);
    reg_writes++;
    case (idx)
      REG_BIMODAL_ENABLE: bimodal = val[0];
      REG_THROTTLE:       throttle = val;
      default: ;
    endcase
  endfunction

  // Applies one accepted access and queues the victim a miss produces.
  function void note_access(logic [SET_IDX_W-1:0] set_idx, logic hit,
                            logic [WAY_IDX_W-1:0] way);
    int      s;
    int      victim;
    bit      found;
    int      thr;
    rrpv_t   ins;
    victim_t exp_v;
    s = int'(set_idx) % SETS;
    if (hit) begin
      hits++;
      if (int'(way) < WAYS) rrpv[s][way] = RRPV_NEAR;
      return;
    end
    misses++;
    // Search for an invalid or distant way, aging the set between passes.
    victim = 0;
    found  = 1'b0;
    for (int pass = 0; pass <= int'(RRPV_MAX) && !found; pass++) begin
      for (int w = 0; w < WAYS && !found; w++) begin
        if (!line_vld[s][w] || rrpv[s][w] == RRPV_MAX) begin
          victim = w;
          found  = 1'b1;
        end
      end
      if (!found) begin
        agings++;
        for (int w = 0; w < WAYS; w++) begin
          if (rrpv[s][w] < RRPV_MAX) rrpv[s][w] = rrpv[s][w] + 2'd1;
        end
      end
    end
    exp_v.way       = victim[WAY_IDX_W-1:0];
    exp_v.was_valid = line_vld[s][victim];
    // Bimodal insertion: zero throttle acts as one, large values are capped.
    ins = RRPV_LONG;
    if (bimodal) begin
      thr = int'(throttle);
      if (thr == 0) thr = 1;
      if (thr > int'(THROTTLE_CAP)) thr = int'(THROTTLE_CAP);
      miss_cnt = CNT_W'((int'(miss_cnt) + 1) % thr);
      if (miss_cnt == '0) begin
        ins = RRPV_NEAR;
        near_inserts++;
      end
    end
    line_vld[s][victim] = 1'b1;
    rrpv[s][victim]     = ins;
    pending_victims.push_back(exp_v);
  endfunction

  function void check_victim(logic [WAY_IDX_W-1:0] way, logic was_valid);
    victim_t exp_v;
    if (pending_victims.size() == 0) begin
      $error("unexpected victim transaction: victim_way %0d", way);
      errors++;
      return;
    end
    exp_v = pending_victims.pop_front();
    if (way !== exp_v.way) begin
      $error("victim_way mismatch: expected %0d, actual %0d", exp_v.way, way);
      errors++;
    end
    if (was_valid !== exp_v.was_valid) begin
      $error("victim_was_valid mismatch: expected %0d, actual %0d",
             exp_v.was_valid, was_valid);
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_victims.size();
  endfunction
endclass

module tb_rrip_replacement_controller_unit;
  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 8;
  localparam int DRAIN_WAIT = 12;

  logic clk;
  logic rst;
  int   results_seen;

  victim_scoreboard sb = new();

  rrip_req_if req_ch ();
  rrip_rsp_if rsp_ch ();
  rrip_cfg_if cfg_ch ();

  rrip_replacement_controller_unit #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offers one access and returns at the falling edge after its transaction, or after a random idle gap if may_idle.
  task automatic offer_access(logic [SET_IDX_W-1:0] s, logic h,
                              logic [WAY_IDX_W-1:0] w, bit may_idle);
    req_ch.valid     <= 1'b1;
    req_ch.set_index <= s;
    req_ch.is_hit    <= h;
    req_ch.hit_way   <= w;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_access(s, h, w);
    @(negedge clk);
    if (may_idle && $urandom_range(99) < 37) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  // Stops offering and waits for every outstanding victim plus the hit latency.
  task automatic drain_block();
    req_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [THROTTLE_W-1:0] val);
    drain_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a few busy sets so ways fill, age and get evicted; the rest is noise.
  task automatic random_access(bit may_idle);
    logic [SET_IDX_W-1:0] s;
    logic [SET_IDX_W-1:0] busy_sets [4];
    busy_sets = '{6'd0, 6'd1, 6'd62, 6'd63};
    if ($urandom_range(99) < 80) s = busy_sets[$urandom_range(3)];
    else s = SET_IDX_W'($urandom_range(NUM_SETS - 1));
    offer_access(s, 1'($urandom_range(1)), WAY_IDX_W'($urandom_range(NUM_WAYS - 1)),
                 may_idle);
  endtask

  // Result side: random stalls, one long hold-off and one stretch without stalls.
  initial begin
    bit held_off;
    held_off     = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (results_seen >= 250 && results_seen < 330) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Compare each victim transaction at the rising edge.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_victim(rsp_ch.victim_way, rsp_ch.victim_was_valid);
      results_seen++;
    end
  end

  // Run limit.
  initial begin
    #2ms;
    $display("tb_rrip_replacement_controller_unit: done, errors");
    $finish;
  end

  // Stimulus.
  initial begin
    bit                    phase_bimodal [9];
    logic [THROTTLE_W-1:0] phase_throttle [9];
    int                    phase_items [9];
    int                    wait_cycles;

    phase_bimodal  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    phase_throttle = '{11'd1, 11'd0, 11'd3, 11'd1024, 11'd2047, 11'd1025, 11'd1024,
                       11'd5, 11'd32};
    phase_items    = '{80, 60, 100, 80, 60, 60, 60, 100, 60};
    results_seen     = 0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.set_index = '0;
    req_ch.is_hit    = 1'b0;
    req_ch.hit_way   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_BIMODAL_ENABLE;
    cfg_ch.data      = '0;
    // Hold reset while the clock runs, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fill set 0 from empty, then age it to find a victim.
    for (int w = 0; w < NUM_WAYS; w++) offer_access(6'd0, 1'b0, WAY_IDX_W'(w), 1'b0);
    offer_access(6'd0, 1'b1, 3'd0, 1'b0);
    offer_access(6'd0, 1'b1, 3'd7, 1'b0);
    offer_access(6'd0, 1'b0, 3'd0, 1'b0);
    offer_access(6'd0, 1'b0, 3'd7, 1'b0);
    // A hit on a way that was never filled leaves it invalid.
    offer_access(6'd63, 1'b1, 3'd7, 1'b0);
    offer_access(6'd63, 1'b0, 3'd7, 1'b0);
    offer_access(6'd63, 1'b1, 3'd0, 1'b0);
    offer_access(6'd63, 1'b0, 3'd0, 1'b0);
    // The hit way is ignored on a miss; alternating bit patterns.
    offer_access(6'd42, 1'b0, 3'd5, 1'b0);
    offer_access(6'd21, 1'b1, 3'd2, 1'b0);
    offer_access(6'd42, 1'b1, 3'd5, 1'b0);

    // Random phases, each under its own insertion setting.
    for (int p = 0; p < 9; p++) begin
      write_reg(REG_BIMODAL_ENABLE, {10'd0, phase_bimodal[p]});
      write_reg(REG_THROTTLE, phase_throttle[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 1 && i == phase_items[p] / 2) drain_block();
        random_access(p != 2);
      end
    end

    // Let the block finish, then report.
    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_count() != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (sb.pending_count() != 0) begin
      $error("%0d victim transactions never arrived", sb.pending_count());
      sb.errors++;
    end
    $display("Covered %0d accesses: %0d hits, %0d misses, %0d victims checked.",
             sb.hits + sb.misses, sb.hits, sb.misses, results_seen);
    $display("Saw %0d aging passes and %0d near inserts over %0d register writes.",
             sb.agings, sb.near_inserts, sb.reg_writes);
    if (sb.errors == 0) begin
      $display("tb_rrip_replacement_controller_unit: done, clean");
    end else begin
      $display("tb_rrip_replacement_controller_unit: done, errors");
    end
    $finish;
  end
endmodule
